// ----- sv/sdbs_pkg.sv -----
// Shared constants, entry layout and controller/datapath command types for the directory search.
`default_nettype none

package sdbs_pkg;

  localparam int WORD_W              = 32;
  localparam int ENTRY_IDX_W         = 10;
  localparam int CNT_W               = 11;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One directory entry as it sits in the table RAM
  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] flags;
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] unpacked;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // write the accepted entry into the table
    logic start;    // latch the key and open the search range
    logic step;     // compare the probed entry and narrow the range
    logic publish;  // move the finished result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;    // search range is empty from the start
    logic done;     // current probe ends the search (match or miss)
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/sdbs_if.sv -----
// Valid/ready channel interfaces for request words and result words.
`default_nettype none

interface sdbs_req_if;
  import sdbs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [WORD_W-1:0]      entry_id;
  logic [WORD_W-1:0]      entry_flags;
  logic [WORD_W-1:0]      entry_pos;
  logic [WORD_W-1:0]      entry_len;
  logic [WORD_W-1:0]      entry_unpacked;

  modport source (
    output valid, kind, entry_index, entry_id, entry_flags, entry_pos, entry_len,
           entry_unpacked,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, entry_id, entry_flags, entry_pos, entry_len,
           entry_unpacked,
    output ready
  );
endinterface

interface sdbs_rsp_if;
  import sdbs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [ENTRY_IDX_W-1:0] found_index;
  logic [WORD_W-1:0]      found_flags;
  logic [WORD_W-1:0]      found_pos;
  logic [WORD_W-1:0]      found_len;
  logic [WORD_W-1:0]      found_unpacked;

  modport source (
    output valid, found, found_index, found_flags, found_pos, found_len, found_unpacked,
    input  ready
  );
  modport sink (
    input  valid, found, found_index, found_flags, found_pos, found_len, found_unpacked,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/sorted_directory_binary_search.sv -----
// Top level: sorted directory table with binary-search lookup.
//
//   channel  role    word
//   req      sink    kind, entry_index, entry_id, entry_flags, entry_pos, entry_len,
//                    entry_unpacked
//   rsp      source  found, found_index, found_flags, found_pos, found_len, found_unpacked
//   cfg      write   cfg_we / cfg_wdata -> entry_count
//
// A load word is written into the table RAM at the accept edge. A lookup word makes P
// probes, P being at most ceil(log2(n + 1)) for n searched entries: one probe per
// cycle, set by the registered table RAM read feeding the compare and the next
// midpoint. An empty table skips the probes. The table needs no clearing pass after
// reset. The finished result waits in its step while the output register is still
// held by the sink; rsp keeps its word until taken, and req is not ready during a
// lookup.
`default_nettype none

module sorted_directory_binary_search #(
  parameter int TABLE_DEPTH = sdbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sdbs_pkg::CNT_W-1:0] cfg_wdata,
  sdbs_req_if.sink                   req,
  sdbs_rsp_if.source                 rsp
);
  import sdbs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  sdbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .rsp_ready (rsp.ready),
    .status    (status),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  sdbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .req_index    (req.entry_index),
    .req_id       (req.entry_id),
    .req_flags    (req.entry_flags),
    .req_pos      (req.entry_pos),
    .req_len      (req.entry_len),
    .req_unpacked (req.entry_unpacked),
    .status       (status),
    .rsp_found    (rsp.found),
    .rsp_index    (rsp.found_index),
    .rsp_flags    (rsp.found_flags),
    .rsp_pos      (rsp.found_pos),
    .rsp_len      (rsp.found_len),
    .rsp_unpacked (rsp.found_unpacked)
  );

endmodule

`default_nettype wire

// ----- sv/sdbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdbs_ram #(
  parameter int WIDTH = sdbs_pkg::ENTRY_W,
  parameter int DEPTH = sdbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sdbs_ctrl.sv -----
// Controller state machine: accepts words, sequences the probes, owns the result valid.
`default_nettype none

module sdbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_kind,
  input  logic                 rsp_ready,
  input  sdbs_pkg::dp_status_t status,
  output logic                 req_ready,
  output logic                 rsp_valid,
  output sdbs_pkg::ctl_cmd_t   cmd
);
  import sdbs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  // Decode commands for the datapath
  always_comb begin
    cmd         = '0;
    cmd.load    = accept && (req_kind == KIND_LOAD);
    cmd.start   = accept && (req_kind == KIND_LOOKUP);
    cmd.step    = (state == S_PROBE);
    cmd.publish = (state == S_FINISH) && out_free;
  end

  // Advance the search sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = status.empty ? S_FINISH : S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_PROBE || state == S_FINISH))
    else $error("lookup start did not leave idle");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result valid rose outside the finish step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp_ready) |=> out_valid)
    else $error("pending result word was dropped");

endmodule

`default_nettype wire

// ----- sv/sdbs_dpath.sv -----
// Datapath: count register, entry table, search range, probe compare and result registers.
`default_nettype none

module sdbs_dpath #(
  parameter int TABLE_DEPTH = sdbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sdbs_pkg::CNT_W-1:0]       cfg_wdata,
  input  sdbs_pkg::ctl_cmd_t               cmd,
  input  logic [sdbs_pkg::ENTRY_IDX_W-1:0] req_index,
  input  logic [sdbs_pkg::WORD_W-1:0]      req_id,
  input  logic [sdbs_pkg::WORD_W-1:0]      req_flags,
  input  logic [sdbs_pkg::WORD_W-1:0]      req_pos,
  input  logic [sdbs_pkg::WORD_W-1:0]      req_len,
  input  logic [sdbs_pkg::WORD_W-1:0]      req_unpacked,
  output sdbs_pkg::dp_status_t             status,
  output logic                             rsp_found,
  output logic [sdbs_pkg::ENTRY_IDX_W-1:0] rsp_index,
  output logic [sdbs_pkg::WORD_W-1:0]      rsp_flags,
  output logic [sdbs_pkg::WORD_W-1:0]      rsp_pos,
  output logic [sdbs_pkg::WORD_W-1:0]      rsp_len,
  output logic [sdbs_pkg::WORD_W-1:0]      rsp_unpacked
);
  import sdbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = AW + 1;

  logic [CNT_W-1:0]  entry_count;
  logic [PW-1:0]     cnt_sat;
  logic [PW-1:0]     high0;
  logic [AW-1:0]     mid0;
  logic [WORD_W-1:0] key;
  logic [PW-1:0]     low;
  logic [PW-1:0]     high;
  logic [AW-1:0]     mid;
  logic [PW-1:0]     low_next;
  logic [PW-1:0]     high_next;
  logic [AW-1:0]     mid_next;
  logic [PW-1:0]     mid_ext;
  logic [PW-1:0]     low_up;
  logic [PW-1:0]     high_dn;
  logic [PW:0]       range_sum;
  logic              eq;
  logic              lt;
  logic              miss;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            probe;

  logic                   res_found;
  logic [ENTRY_IDX_W-1:0] res_index;
  logic [WORD_W-1:0]      res_flags;
  logic [WORD_W-1:0]      res_pos;
  logic [WORD_W-1:0]      res_len;
  logic [WORD_W-1:0]      res_unpacked;

  // Entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // Saturate the count to the table depth and open the range
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      cnt_sat = PW'(TABLE_DEPTH);
    end else begin
      cnt_sat = PW'(entry_count);
    end
  end

  assign high0 = cnt_sat - PW'(1);
  assign mid0  = high0[AW:1];

  // Entry table
  assign ram_we    = cmd.load && (32'(req_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(req_index);
  assign ram_wdata = '{id: req_id, flags: req_flags, pos: req_pos, len: req_len,
                       unpacked: req_unpacked};
  assign ram_raddr = cmd.start ? mid0 : mid_next;

  sdbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign probe = entry_t'(ram_rdata);

  // Compare the probed word and narrow the range
  assign eq      = (probe.id == key);
  assign lt      = (probe.id < key);
  assign mid_ext = {1'b0, mid};
  assign low_up  = mid_ext + PW'(1);
  assign high_dn = mid_ext - PW'(1);

  always_comb begin
    low_next  = low;
    high_next = high;
    miss      = 1'b0;
    if (!eq) begin
      if (lt) begin
        low_next = low_up;
        miss     = (low_up > high);
      end else begin
        high_next = high_dn;
        miss      = (mid == '0) || (low > high_dn);
      end
    end
  end

  assign range_sum = {1'b0, low_next} + {1'b0, high_next};
  assign mid_next  = range_sum[AW:1];

  assign status.empty = (cnt_sat == '0);
  assign status.done  = eq || miss;

  // Search range registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key  <= req_id;
      low  <= '0;
      high <= high0;
      mid  <= mid0;
    end else if (cmd.step && !status.done) begin
      low  <= low_next;
      high <= high_next;
      mid  <= mid_next;
    end
  end

  // Capture the result: entry on a match, zeros on a miss or an empty table
  always_ff @(posedge clk) begin
    if ((cmd.start && status.empty) || (cmd.step && miss)) begin
      res_found    <= 1'b0;
      res_index    <= '0;
      res_flags    <= '0;
      res_pos      <= '0;
      res_len      <= '0;
      res_unpacked <= '0;
    end else if (cmd.step && eq) begin
      res_found    <= 1'b1;
      res_index    <= ENTRY_IDX_W'(mid);
      res_flags    <= probe.flags;
      res_pos      <= probe.pos;
      res_len      <= probe.len;
      res_unpacked <= probe.unpacked;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp_found    <= res_found;
      rsp_index    <= res_index;
      rsp_flags    <= res_flags;
      rsp_pos      <= res_pos;
      rsp_len      <= res_len;
      rsp_unpacked <= res_unpacked;
    end
  end

  a_range_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !status.done) |=> (low <= high))
    else $error("search continued on an empty range");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (mid_ext >= low) && (mid_ext <= high))
    else $error("probe address outside the search range");

  a_high_in_table: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && !status.empty) |=> (high < PW'(TABLE_DEPTH)))
    else $error("search range runs past the table");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the sorted directory search: directed table, then random phases.
module tb_top;
  import sdbs_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int MAX_WAIT = 11;
  localparam int SETTLE_CYCLES = 16;
  localparam int WORD_TARGET = 1800;

  typedef enum logic {ROW_WORD, ROW_COUNT} row_op_t;

  typedef struct packed {
    logic                   kind;
    logic [ENTRY_IDX_W-1:0] slot;
    logic [WORD_W-1:0]      id;
    logic [WORD_W-1:0]      flags;
    logic [WORD_W-1:0]      pos;
    logic [WORD_W-1:0]      len;
    logic [WORD_W-1:0]      unpacked;
  } req_word_t;

  typedef struct packed {
    logic                   found;
    logic [ENTRY_IDX_W-1:0] index;
    logic [WORD_W-1:0]      flags;
    logic [WORD_W-1:0]      pos;
    logic [WORD_W-1:0]      len;
    logic [WORD_W-1:0]      unpacked;
  } result_t;

  typedef struct packed {
    row_op_t          op;
    logic [CNT_W-1:0] count;
    req_word_t        word;
    logic             typed;
    result_t          want;
  } dir_row_t;

  localparam result_t NOT_FOUND = '0;
  localparam req_word_t NO_WORD = '0;
  localparam logic [WORD_W-1:0] ONES = 32'hFFFF_FFFF;

  // Directed rows: a typed result is given only where it is obvious
  localparam int NUM_ROWS = 24;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, ONES, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd1, 32'h1000, 32'h1, 32'h100, 32'h20, 32'h40},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd2, 32'h8000_0000, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
      32'h1234_5678, 32'h8765_4321}, 1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd3, ONES, ONES, ONES, ONES, ONES},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd1023, 32'h1234, 32'hFF, 32'hFFFF_0000,
      32'h0000_FFFF, 32'hFF00_FF00}, 1'b0, NOT_FOUND},
    // loads alone do not open the table
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    '{ROW_COUNT, 11'd4, NO_WORD, 1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, '{1'b1, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, ONES, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, '{1'b1, 10'd3, ONES, ONES, ONES, ONES}},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, '{1'b1, 10'd1, 32'h1, 32'h100, 32'h20, 32'h40}},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0FFF, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    '{ROW_COUNT, 11'd1, NO_WORD, 1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND},
    // present in the table but beyond the count
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b1, NOT_FOUND},
    // rewrite slots 2 and 1, repeating the id of slot 0
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd2, 32'h10, 32'h7, 32'h8, 32'h9, 32'hA},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOAD, 10'd1, 32'h0, 32'h2, 32'h3, 32'h4, 32'h5},
      1'b0, NOT_FOUND},
    '{ROW_COUNT, 11'd3, NO_WORD, 1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h10, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND},
    '{ROW_WORD, 11'd0, '{KIND_LOOKUP, 10'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0},
      1'b0, NOT_FOUND}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  sdbs_req_if req_ch ();
  sdbs_rsp_if rsp_ch ();

  sorted_directory_binary_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the directory and its count
  bit [WORD_W-1:0] shadow_id       [DEPTH];
  bit [WORD_W-1:0] shadow_flags    [DEPTH];
  bit [WORD_W-1:0] shadow_pos      [DEPTH];
  bit [WORD_W-1:0] shadow_len      [DEPTH];
  bit [WORD_W-1:0] shadow_unpacked [DEPTH];
  int              shadow_count = 0;

  result_t pending_results [$];
  int      words_sent = 0;
  int      mismatches = 0;
  bit      quiet_gaps = 1'b0;

  function automatic int draw_wait();
    return quiet_gaps ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Probe mid of an inclusive range, narrowing until a match or an empty range
  function automatic result_t search_directory(input logic [WORD_W-1:0] key);
    int lo;
    int hi;
    int mid;
    result_t r;
    r = NOT_FOUND;
    lo = 0;
    hi = ((shadow_count > DEPTH) ? DEPTH : shadow_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_id[mid] == key) begin
        r.found    = 1'b1;
        r.index    = ENTRY_IDX_W'(mid);
        r.flags    = shadow_flags[mid];
        r.pos      = shadow_pos[mid];
        r.len      = shadow_len[mid];
        r.unpacked = shadow_unpacked[mid];
        return r;
      end
      if (shadow_id[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  // Mostly keys that sit in the searched range, their neighbors, then the ends and noise
  function automatic logic [WORD_W-1:0] pick_key();
    int span;
    int r;
    logic [WORD_W-1:0] hit;
    span = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    r = $urandom_range(0, 19);
    if (span == 0 || r >= 15) return $urandom;
    hit = shadow_id[$urandom_range(0, span - 1)];
    if (r < 9) return hit;
    if (r < 12) return hit + 1;
    if (r < 14) return hit - 1;
    return $urandom_range(0, 1) ? ONES : '0;
  endfunction

  function automatic req_word_t make_word(input logic kind, input logic [ENTRY_IDX_W-1:0] slot,
                                          input logic [WORD_W-1:0] id);
    req_word_t w;
    w.kind     = kind;
    w.slot     = slot;
    w.id       = id;
    w.flags    = $urandom;
    w.pos      = $urandom;
    w.len      = $urandom;
    w.unpacked = $urandom;
    return w;
  endfunction

  // Present one word, hold it until taken, then record its effect
  task automatic send_word(input req_word_t w, input bit typed, input result_t typed_res);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.kind           <= w.kind;
    req_ch.entry_index    <= w.slot;
    req_ch.entry_id       <= w.id;
    req_ch.entry_flags    <= w.flags;
    req_ch.entry_pos      <= w.pos;
    req_ch.entry_len      <= w.len;
    req_ch.entry_unpacked <= w.unpacked;
    do @(posedge clk); while (!req_ch.ready);
    if (w.kind == KIND_LOAD) begin
      shadow_id[w.slot]       = w.id;
      shadow_flags[w.slot]    = w.flags;
      shadow_pos[w.slot]      = w.pos;
      shadow_len[w.slot]      = w.len;
      shadow_unpacked[w.slot] = w.unpacked;
    end else begin
      pending_results.push_back(typed ? typed_res : search_directory(w.id));
    end
    words_sent++;
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(input logic [CNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_count = value;
  endtask

  // Write slots from zero up with ascending ids; some tables repeat ids, a few are scrambled
  task automatic load_sorted_prefix(input int n);
    int style;
    logic [WORD_W-1:0] id;
    style = $urandom_range(0, 9);
    id = $urandom_range(0, 32'hF000_0000);
    for (int i = 0; i < n; i++) begin
      if (style == 9) id = $urandom;
      else if (style < 7 || $urandom_range(0, 2) != 0) id = id + $urandom_range(1, 1 << 20);
      send_word(make_word(KIND_LOAD, ENTRY_IDX_W'(i), id), 1'b0, NOT_FOUND);
    end
  endtask

  // Lookups with an occasional stray load anywhere in the table
  task automatic lookup_burst(input int k);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(make_word(KIND_LOAD, ENTRY_IDX_W'($urandom_range(0, DEPTH - 1)), $urandom),
                  1'b0, NOT_FOUND);
      else
        send_word(make_word(KIND_LOOKUP, ENTRY_IDX_W'($urandom_range(0, DEPTH - 1)),
                            pick_key()), 1'b0, NOT_FOUND);
    end
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, found %b index %0d",
                 $time, rsp_ch.found, rsp_ch.found_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", WORD_W'(want.found), WORD_W'(rsp_ch.found));
        check_field("found_index", WORD_W'(want.index), WORD_W'(rsp_ch.found_index));
        check_field("found_flags", want.flags, rsp_ch.found_flags);
        check_field("found_pos", want.pos, rsp_ch.found_pos);
        check_field("found_len", want.len, rsp_ch.found_len);
        check_field("found_unpacked", want.unpacked, rsp_ch.found_unpacked);
      end
    end
  end

  // Result side: stall a random number of cycles before taking each word
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int n;
    int pick;
    logic [WORD_W-1:0] acc;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.kind           = KIND_LOAD;
    req_ch.entry_index    = '0;
    req_ch.entry_id       = '0;
    req_ch.entry_flags    = '0;
    req_ch.entry_pos      = '0;
    req_ch.entry_len      = '0;
    req_ch.entry_unpacked = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].op == ROW_COUNT) set_entry_count(DIRECTED[i].count);
      else send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Fill the whole table in order, then search it at full size and past it
    acc = $urandom_range(0, 1000);
    for (int i = 0; i < DEPTH; i++) begin
      acc = acc + $urandom_range(1, 4000000);
      send_word(make_word(KIND_LOAD, ENTRY_IDX_W'(i), acc), 1'b0, NOT_FOUND);
    end
    set_entry_count(CNT_W'(DEPTH));
    lookup_burst(120);
    quiet_gaps = 1'b1;
    set_entry_count(CNT_W'($urandom_range(DEPTH + 1, 2046)));
    lookup_burst(30);
    quiet_gaps = 1'b0;
    set_entry_count({CNT_W{1'b1}});
    lookup_burst(30);

    // Small tables, mostly sorted, with a count that sometimes does not match
    while (words_sent < WORD_TARGET) begin
      quiet_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      n = (pick < 7) ? $urandom_range(1, 24) : (pick < 9) ? $urandom_range(25, 160) : 0;
      load_sorted_prefix(n);
      set_entry_count(CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : n));
      lookup_burst($urandom_range(8, 30));
    end

    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Hang guard
  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule
